[rtl/core/gated_object_track_table_core_defines.svh]
// Assertion macros for the gated object track table checker.
// No dependencies; included by the checker file only.
`ifndef GATED_OBJECT_TRACK_TABLE_CORE_DEFINES_SVH
`define GATED_OBJECT_TRACK_TABLE_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define GOTT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define GOTT_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/gott_pkg.sv]
// Shared types, constants and codes of the gated object track table.
// No dependencies.
`default_nettype none

package gott_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int NRES_W          = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] STS_UPDATED  = 3'd0;
    localparam logic [2:0] STS_INSERTED = 3'd1;
    localparam logic [2:0] STS_DROPPED  = 3'd2;
    localparam logic [2:0] STS_MATCH    = 3'd3;
    localparam logic [2:0] STS_NONE     = 3'd4;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [2:0]  GATE_ADDR  = 3'h0;
    localparam logic [18:0] GATE_RESET = 19'd512;

    // floor(u/5) = (u * ceil(2^25/5)) >> 25 for u < 2^23
    localparam logic [22:0] BLEND_MUL   = 23'd6710887;
    localparam int          BLEND_SHIFT = 25;
    localparam logic signed [23:0] BLEND_OFS = 24'sd2621440;
    localparam logic [20:0] BLEND_BIAS  = 21'd524288;

    typedef struct packed {
        logic               op;
        logic [7:0]         obj_cls;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         entry_index;
        logic [7:0]         entry_class;
        logic signed [19:0] out_x;
        logic signed [19:0] out_y;
        logic signed [19:0] out_z;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]         cls;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
    } t_entry;

    typedef struct packed {
        logic load;
        logic next;
        logic diff;
        logic sq;
        logic blend;
        logic upd;
        logic ins;
        logic drop;
        logic pend;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic at_end;
        logic class_eq;
        logic in_gate;
        logic full;
        logic res_full;
    } t_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_SQ,
        S_CMP,
        S_WR
    } t_state;

endpackage

`default_nettype wire

[rtl/core/gott_dpath.sv]
// Datapath: track memory, scan index, distance and blend arithmetic, result register.
// Depends on gott_pkg.
`default_nettype none

module gott_dpath #(
    parameter int TABLE_DEPTH = gott_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gott_pkg::t_cmd      i_cmd,
    input  wire gott_pkg::t_in_item  i_item,
    input  wire logic [18:0]         i_gate,
    output gott_pkg::t_stat          o_stat,
    output logic                     o_valid,
    output gott_pkg::t_out_item      o_result
);
    import gott_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_entry             r_mem [TABLE_DEPTH];
    t_entry             r_rd;
    t_in_item           r_item;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_count;
    logic [37:0]        r_gate2;
    logic signed [20:0] r_dx, r_dy, r_dz;
    logic [40:0]        r_sqx, r_sqy, r_sqz;
    logic [45:0]        r_px, r_py, r_pz;
    t_entry             r_pend;
    logic [CW-1:0]      r_pend_idx;
    logic               r_pend_v;
    logic [NRES_W-1:0]  r_nres;
    logic               r_valid;
    t_out_item          r_out;

    logic signed [41:0] sq_x, sq_y, sq_z;
    logic [42:0]        dist2;
    logic signed [23:0] ux, uy, uz;
    logic [45:0]        px, py, pz;
    logic [20:0]        qx, qy, qz;
    logic [19:0]        bx, by, bz;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    t_entry             wr_data;

    assign sq_x  = r_dx * r_dx;
    assign sq_y  = r_dy * r_dy;
    assign sq_z  = r_dz * r_dz;
    assign dist2 = {2'b0, r_sqx} + {2'b0, r_sqy} + {2'b0, r_sqz};

    assign ux = ($signed({{4{r_rd.x[19]}}, r_rd.x}) <<< 2)
              + $signed({{4{r_item.pos_x[19]}}, r_item.pos_x}) + BLEND_OFS;
    assign uy = ($signed({{4{r_rd.y[19]}}, r_rd.y}) <<< 2)
              + $signed({{4{r_item.pos_y[19]}}, r_item.pos_y}) + BLEND_OFS;
    assign uz = ($signed({{4{r_rd.z[19]}}, r_rd.z}) <<< 2)
              + $signed({{4{r_item.pos_z[19]}}, r_item.pos_z}) + BLEND_OFS;
    assign px = ux[22:0] * BLEND_MUL;
    assign py = uy[22:0] * BLEND_MUL;
    assign pz = uz[22:0] * BLEND_MUL;

    assign qx = r_px[BLEND_SHIFT+20:BLEND_SHIFT] - BLEND_BIAS;
    assign qy = r_py[BLEND_SHIFT+20:BLEND_SHIFT] - BLEND_BIAS;
    assign qz = r_pz[BLEND_SHIFT+20:BLEND_SHIFT] - BLEND_BIAS;
    assign bx = qx[19:0];
    assign by = qy[19:0];
    assign bz = qz[19:0];

    always_comb begin
        wr_en   = i_cmd.upd | (i_cmd.ins & (r_count < CW'(TABLE_DEPTH)));
        wr_addr = i_cmd.upd ? r_idx[IW-1:0] : r_count[IW-1:0];
        if (i_cmd.upd) begin
            wr_data = '{cls: r_rd.cls, x: bx, y: by, z: bz};
        end else begin
            wr_data = '{cls: r_item.obj_cls, x: r_item.pos_x,
                        y: r_item.pos_y, z: r_item.pos_z};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_item;
            r_gate2 <= i_gate * i_gate;
        end
        if (i_cmd.diff) begin
            r_dx <= $signed({r_item.pos_x[19], r_item.pos_x}) - $signed({r_rd.x[19], r_rd.x});
            r_dy <= $signed({r_item.pos_y[19], r_item.pos_y}) - $signed({r_rd.y[19], r_rd.y});
            r_dz <= $signed({r_item.pos_z[19], r_item.pos_z}) - $signed({r_rd.z[19], r_rd.z});
        end
        if (i_cmd.sq) begin
            r_sqx <= sq_x[40:0];
            r_sqy <= sq_y[40:0];
            r_sqz <= sq_z[40:0];
        end
        if (i_cmd.blend) begin
            r_px <= px;
            r_py <= py;
            r_pz <= pz;
        end
        if (i_cmd.pend) begin
            r_pend     <= r_rd;
            r_pend_idx <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_nres   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_pend_v <= 1'b0;
                r_nres   <= '0;
            end else if (i_cmd.next) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.ins) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.pend) begin
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_nres <= r_nres + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.upd | i_cmd.ins | i_cmd.drop | i_cmd.flush
                     | (i_cmd.pend & r_pend_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_out <= '{status: STS_UPDATED, entry_index: 5'(r_idx), entry_class: r_rd.cls,
                       out_x: bx, out_y: by, out_z: bz, last: 1'b1};
        end else if (i_cmd.ins) begin
            r_out <= '{status: STS_INSERTED, entry_index: 5'(r_count),
                       entry_class: r_item.obj_cls, out_x: r_item.pos_x,
                       out_y: r_item.pos_y, out_z: r_item.pos_z, last: 1'b1};
        end else if (i_cmd.drop) begin
            r_out <= '{status: STS_DROPPED, entry_index: 5'd0,
                       entry_class: r_item.obj_cls, out_x: r_item.pos_x,
                       out_y: r_item.pos_y, out_z: r_item.pos_z, last: 1'b1};
        end else if (i_cmd.pend | i_cmd.flush) begin
            if (r_pend_v) begin
                r_out <= '{status: STS_MATCH, entry_index: 5'(r_pend_idx),
                           entry_class: r_pend.cls, out_x: r_pend.x, out_y: r_pend.y,
                           out_z: r_pend.z, last: i_cmd.flush};
            end else begin
                r_out <= '{status: STS_NONE, entry_index: 5'd0,
                           entry_class: r_item.obj_cls, out_x: 20'sd0,
                           out_y: 20'sd0, out_z: 20'sd0, last: 1'b1};
            end
        end
    end

    assign o_stat.is_query = (r_item.op == OP_QUERY);
    assign o_stat.at_end   = (r_idx >= r_count);
    assign o_stat.class_eq = (r_rd.cls == r_item.obj_cls);
    assign o_stat.in_gate  = (dist2 < {5'b0, r_gate2});
    assign o_stat.full     = (r_count >= CW'(TABLE_DEPTH));
    assign o_stat.res_full = r_pend_v && (r_nres == NRES_W'(MAX_RESULTS - 1));

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

[rtl/core/gott_ctrl.sv]
// Controller: sequences the table scan, distance check, blend and result emission.
// Depends on gott_pkg.
`default_nettype none

module gott_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire gott_pkg::t_stat i_stat,
    output gott_pkg::t_cmd       o_cmd,
    output logic                 o_busy
);
    import gott_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.at_end || (i_stat.is_query && i_stat.res_full)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (!i_stat.is_query && i_stat.class_eq) begin
                    n_state = S_SQ;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SQ:  n_state = S_CMP;
            S_CMP: n_state = i_stat.in_gate ? S_WR : S_SCAN;
            S_WR:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.load = i_start;
            S_SCAN: begin
                if (i_stat.is_query) begin
                    o_cmd.flush = i_stat.at_end || i_stat.res_full;
                end else if (i_stat.at_end) begin
                    o_cmd.drop = i_stat.full;
                    o_cmd.ins  = !i_stat.full;
                end
            end
            S_RD: begin
                if (i_stat.is_query) begin
                    o_cmd.pend = i_stat.class_eq;
                    o_cmd.next = 1'b1;
                end else begin
                    o_cmd.diff = i_stat.class_eq;
                    o_cmd.next = !i_stat.class_eq;
                end
            end
            S_SQ: o_cmd.sq = 1'b1;
            S_CMP: begin
                o_cmd.blend = i_stat.in_gate;
                o_cmd.next  = !i_stat.in_gate;
            end
            S_WR: o_cmd.upd = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

[rtl/core/gated_object_track_table_core.sv]
// Top level of the gated object track table: APB gate register, controller, datapath.
// Depends on gott_pkg, gott_ctrl, gott_dpath.
//
// Usage:
//   Command channel: present i_item and raise start; the item is taken at an
//   edge with start high and busy low. busy stays high until the last result.
//   Result channel: o_valid strobes for one cycle per result with o_result;
//   o_result.last marks the final result of the item. The receiver cannot
//   stall, so results must be taken as they come.
//   Config: APB register gate_distance at byte address 0, written with busy low.
// Scan (one entry visited at a time on the single-port table memory):
//   each entry visited is read, and each same-class entry of an update also
//   has its distance checked; the write of an update hit takes the place of
//   the final scan state.
//   Query results appear during the scan; each match is held until the next
//   match is found or the scan ends.
// Reset: table empty, gate 512. No clearing pass; entries are written before read.
`default_nettype none

module gated_object_track_table_core #(
    parameter int TABLE_DEPTH = gott_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire gott_pkg::t_in_item  i_item,
    output logic                     o_valid,
    output gott_pkg::t_out_item      o_result,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import gott_pkg::*;

    logic [18:0] r_gate;
    t_cmd        cmd;
    t_stat       stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate <= GATE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == GATE_ADDR)) begin
            r_gate <= pwdata[18:0];
        end
    end

    assign prdata = (paddr == GATE_ADDR) ? {13'b0, r_gate} : 32'b0;

    gott_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    gott_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .i_gate   (r_gate),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

[rtl/core/gott_chk.sv]
// Port-level checker for the gated object track table, bound to the top level.
// Depends on gott_pkg and gated_object_track_table_core_defines.svh.
`default_nettype none
`include "gated_object_track_table_core_defines.svh"

module gott_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                busy,
    input wire logic                o_valid,
    input wire gott_pkg::t_out_item o_result
);
    import gott_pkg::*;

    `GOTT_ASSERT(a_strobe_in_item, i_clk, i_rst_n, o_valid |-> $past(busy), "result without item")
    `GOTT_ASSERT(a_last_frees, i_clk, i_rst_n, o_valid && o_result.last |-> !busy, "busy after last")
    `GOTT_ASSERT(a_more_busy, i_clk, i_rst_n, o_valid && !o_result.last |-> busy, "idle mid item")
    `GOTT_ASSERT(a_upd_last, i_clk, i_rst_n, o_valid && o_result.status != STS_MATCH |-> o_result.last, "single result not last")
    `GOTT_ASSERT_ALL(a_reset_idle, i_clk, $past(!i_rst_n) |-> !busy && !o_valid, "not idle after reset")

endmodule

bind gated_object_track_table_core gott_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

[tb/sv/gott_checker.sv]
// Checker for the gated object track table: tracks the table, predicts results, compares.
// Depends on gott_pkg; instantiated by tb_top beside the block.
`default_nettype none

module gott_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire gott_pkg::t_in_item  i_item,
    input  wire logic                o_valid,
    input  wire gott_pkg::t_out_item o_result,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    input  wire logic                pready,
    output int                       o_fail_count,
    output int                       o_pending
);
    import gott_pkg::*;

    t_entry     tracks[TABLE_DEPTH_DEF];
    int         track_count;
    logic [18:0] gate;
    t_out_item  expected_q[$];

    assign o_pending = expected_q.size();

    function automatic logic signed [19:0] blend_axis(logic signed [19:0] old_v,
                                                        logic signed [19:0] new_v);
        longint s;
        longint q;
        s = 4 * longint'(old_v) + longint'(new_v);
        q = s / 5;
        if ((s % 5) != 0 && s < 0) q = q - 1;
        return q[19:0];
    endfunction

    function automatic longint sq_axis(logic signed [19:0] a, logic signed [19:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    function automatic t_out_item make_result(logic [2:0] sts, int idx, logic [7:0] cls,
                                              logic signed [19:0] x, logic signed [19:0] y,
                                              logic signed [19:0] z, logic lst);
        t_out_item r;
        r.status = sts;
        r.entry_index = idx[4:0];
        r.entry_class = cls;
        r.out_x = x;
        r.out_y = y;
        r.out_z = z;
        r.last = lst;
        return r;
    endfunction

    function automatic void queue_result(t_out_item r);
        expected_q = {expected_q, r};
    endfunction

    task automatic predict_item(t_in_item it);
        longint gate2;
        longint d2;
        int n;
        gate2 = longint'(gate) * longint'(gate);
        if (it.op == OP_UPDATE) begin
            for (int i = 0; i < track_count; i++) begin
                if (tracks[i].cls != it.obj_cls) continue;
                d2 = sq_axis(it.pos_x, tracks[i].x) + sq_axis(it.pos_y, tracks[i].y)
                     + sq_axis(it.pos_z, tracks[i].z);
                if (d2 < gate2) begin
                    tracks[i].x = blend_axis(tracks[i].x, it.pos_x);
                    tracks[i].y = blend_axis(tracks[i].y, it.pos_y);
                    tracks[i].z = blend_axis(tracks[i].z, it.pos_z);
                    queue_result(make_result(STS_UPDATED, i, it.obj_cls,
                        tracks[i].x, tracks[i].y, tracks[i].z, 1'b1));
                    return;
                end
            end
            if (track_count < TABLE_DEPTH_DEF) begin
                tracks[track_count] = {it.obj_cls, it.pos_x, it.pos_y, it.pos_z};
                queue_result(make_result(STS_INSERTED, track_count, it.obj_cls,
                    it.pos_x, it.pos_y, it.pos_z, 1'b1));
                track_count++;
            end else begin
                queue_result(make_result(STS_DROPPED, 0, it.obj_cls,
                    it.pos_x, it.pos_y, it.pos_z, 1'b1));
            end
        end else begin
            n = 0;
            for (int i = 0; i < track_count && n < MAX_RESULTS; i++) begin
                if (tracks[i].cls == it.obj_cls) begin
                    queue_result(make_result(STS_MATCH, i, it.obj_cls,
                        tracks[i].x, tracks[i].y, tracks[i].z, 1'b0));
                    n++;
                end
            end
            if (n == 0)
                queue_result(make_result(STS_NONE, 0, it.obj_cls,
                    20'sd0, 20'sd0, 20'sd0, 1'b1));
            else
                expected_q[$].last = 1'b1;
        end
    endtask

    task automatic report_mismatch(string what, t_out_item got, t_out_item exp);
        $display("%t %s: got %h exp %h", $time, what, got, exp);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item exp;
        if (!i_rst_n) begin
            track_count = 0;
            gate = GATE_RESET;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (o_valid) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", o_result, o_result);
                end else begin
                    exp = expected_q.pop_front();
                    if (o_result !== exp) report_mismatch("field mismatch", o_result, exp);
                end
            end
            if (psel && penable && pwrite && pready && paddr == GATE_ADDR)
                gate = pwdata[18:0];
            if (start && !busy) predict_item(i_item);
        end
    end
endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench top for gated_object_track_table_core: clock, reset, stimulus, verdict.
// Depends on gott_pkg, gott_checker and the block.
`default_nettype none

module tb_top;
    import gott_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        o_valid;
    t_out_item   o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    bit          quiet;

    gated_object_track_table_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_result(o_result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gott_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_result(o_result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("gated_object_track_table_core: mismatch");
        $finish;
    end

    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // start stays high across back-to-back items; lowered only for a gap
    task automatic send_item(t_in_item it);
        i_item <= it;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_gate(logic [18:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= GATE_ADDR;
        pwdata <= {13'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic t_in_item mk(logic op, logic [7:0] cls, int x, int y, int z);
        t_in_item it;
        it.op = op;
        it.obj_cls = cls;
        it.pos_x = x[19:0];
        it.pos_y = y[19:0];
        it.pos_z = z[19:0];
        return it;
    endfunction

    function automatic int rand_pos();
        int r;
        r = $urandom;
        return (r <<< 12) >>> 12;
    endfunction

    // near-miss detections around a spot so gating and blending get exercised
    function automatic t_in_item rand_item(int cx, int cy, int cz, logic [7:0] cls);
        int spread;
        if ($urandom_range(0, 9) == 0)
            return mk(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), rand_pos(),
                      rand_pos(), rand_pos());
        spread = $urandom_range(0, 1) ? 600 : 60;
        return mk($urandom_range(0, 4) == 0, cls + 8'($urandom_range(0, 2)),
                  cx + $urandom_range(0, 2 * spread) - spread,
                  cy + $urandom_range(0, 2 * spread) - spread,
                  cz + $urandom_range(0, 2 * spread) - spread);
    endfunction

    initial begin
        int cx;
        int cy;
        int cz;
        logic [7:0] cls;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty query, extremes, gate boundary, blend floor
        send_item(mk(OP_QUERY, 8'd0, 0, 0, 0));
        send_item(mk(OP_UPDATE, 8'd255, 524287, 524287, 524287));
        send_item(mk(OP_UPDATE, 8'd0, -524288, -524288, -524288));
        send_item(mk(OP_UPDATE, 8'd0, -524288 + 512, -524288, -524288));
        send_item(mk(OP_UPDATE, 8'd0, -524288 + 511, -524288, -524288));
        send_item(mk(OP_UPDATE, 8'd7, -3, 4, 0));
        send_item(mk(OP_UPDATE, 8'd7, -1, 2, -7));
        send_item(mk(OP_UPDATE, 8'd255, 524287, 524287, 524000));
        send_item(mk(OP_QUERY, 8'd0, 0, 0, 0));
        send_item(mk(OP_QUERY, 8'd255, 0, 0, 0));
        send_item(mk(OP_QUERY, 8'd7, 0, 0, 0));
        drain();
        write_gate(19'd0);
        send_item(mk(OP_UPDATE, 8'd7, -1, 2, -7));
        for (int i = 0; i < 28; i++) send_item(mk(OP_UPDATE, 8'd9, i, -i, i));
        send_item(mk(OP_UPDATE, 8'd9, 1, 1, 1));
        send_item(mk(OP_QUERY, 8'd9, 0, 0, 0));
        drain();
        write_gate(19'h7FFFF);
        send_item(mk(OP_UPDATE, 8'd9, 524287, -524288, 0));
        send_item(mk(OP_QUERY, 8'd9, 0, 0, 0));
        drain();

        // random phases with varying gates
        for (int ph = 0; ph < 8; ph++) begin
            i_rst_n <= 1'b1;
            if (ph == 7) quiet = 1'b1;
            write_gate(ph == 0 ? 19'd0 : ph == 1 ? 19'h7FFFF : ph == 2 ? 19'd1 :
                       19'($urandom_range(50, 2000)));
            for (int n = 0; n < 50; n++) begin
                if (n % 10 == 0) begin
                    cx = rand_pos();
                    cy = rand_pos();
                    cz = rand_pos();
                    cls = 8'($urandom_range(0, 255));
                end
                send_item(rand_item(cx, cy, cz, cls));
                idle_burst();
            end
            drain();
        end

        if (fail_count == 0)
            $display("gated_object_track_table_core: match");
        else
            $display("gated_object_track_table_core: mismatch");
        $finish;
    end
endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/gott_pkg.sv
rtl/core/gott_dpath.sv
rtl/core/gott_ctrl.sv
rtl/core/gated_object_track_table_core.sv
rtl/core/gott_chk.sv
tb/sv/gott_checker.sv
tb/sv/tb_top.sv
